>>> rtl/core/ntsc_composite_palette_color_macros.svh
// ============================================================================
// Assertion macros for the composite palette color block
// Shared property forms used by the checker of the block.
// ============================================================================
`ifndef NTSC_COMPOSITE_PALETTE_COLOR_MACROS_SVH
`define NTSC_COMPOSITE_PALETTE_COLOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CPC_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CPC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/ntsc_cpc_pkg.sv
// ============================================================================
// Composite palette color package
// Constants, level and phase tables and the gamma lookup table.
// ============================================================================
package ntsc_cpc_pkg;

   localparam int GammaTableBits = 10;
   localparam int GammaDepth     = 1 << GammaTableBits;
   localparam int Phases         = 12;
   localparam int HalfPhases     = Phases / 2;

   // Q14 constants.
   localparam logic [14:0] BlackQ14 = 15'd8487;
   localparam logic [13:0] AttenQ14 = 14'd12222;
   localparam logic [14:0] FullQ14  = 15'd16384;

   typedef logic [14:0] level_type;
   typedef logic [15:0] gamma_tab_type [GammaDepth];

   // Signal levels: low levels first, then high levels.
   localparam level_type LevelTab [8] = '{
      15'd5734, 15'd8487, 15'd15761, 15'd25395,
      15'd17924, 15'd24674, 15'd32145, 15'd32145
   };

   // First half of the phase tables; the second half is the negation.
   localparam logic signed [31:0] CosTab [HalfPhases] = '{
      32'sd16384, 32'sd14189, 32'sd8192, 32'sd0, -32'sd8192, -32'sd14189
   };
   localparam logic signed [31:0] SinTab [HalfPhases] = '{
      32'sd0, 32'sd8192, 32'sd14189, 32'sd16384, 32'sd14189, 32'sd8192
   };

   // Q20 scale factors for Y and for I and Q.
   localparam logic signed [36:0] YScale = 37'sd60514;
   localparam logic signed [50:0] CScale = 51'sd121027;

   // RGB matrix, Q14, coefficient pairs for I and Q.
   localparam logic signed [35:0] CoefRI =  36'sd15514;
   localparam logic signed [35:0] CoefRQ =  36'sd10216;
   localparam logic signed [35:0] CoefGI = -36'sd4502;
   localparam logic signed [35:0] CoefGQ = -36'sd10415;
   localparam logic signed [35:0] CoefBI = -36'sd18162;
   localparam logic signed [35:0] CoefBQ =  36'sd28000;

   // True when phase p lies in the high half of the wave for hue c.
   function automatic logic in_wave(input logic [3:0] p, input logic [3:0] c);
      logic [5:0] v;
      v = 6'(c) + 6'(p) + 6'd8;
      if (v >= 6'd24) begin
         v = v - 6'd24;
      end else if (v >= 6'd12) begin
         v = v - 6'd12;
      end
      return v < 6'd6;
   endfunction

   // Q30 power with truncation after each step.
   function automatic logic [63:0] pow_q30(input logic [63:0] u, input int n);
      logic [63:0] p;
      p = u;
      for (int k = 1; k < n; k++) begin
         p = (p * u) >> 30;
      end
      return p;
   endfunction

   // Gamma table: u is the largest Q30 value with u^9 <= k/depth, entry is 65535*u^11.
   function automatic gamma_tab_type build_gamma_tab();
      gamma_tab_type t;
      logic [63:0]   x;
      logic [63:0]   lo;
      logic [63:0]   hi;
      logic [63:0]   mid;
      logic [63:0]   prod;
      for (int k = 0; k < GammaDepth; k++) begin
         x  = 64'(k) << (30 - GammaTableBits);
         lo = 64'd0;
         hi = 64'd1 << 30;
         while (lo < hi) begin
            mid = (lo + hi + 64'd1) >> 1;
            if (pow_q30(mid, 9) <= x) begin
               lo = mid;
            end else begin
               hi = mid - 64'd1;
            end
         end
         prod = (pow_q30(lo, 11) * 64'd65535) >> 30;
         t[k] = prod[15:0];
      end
      return t;
   endfunction

   localparam gamma_tab_type GammaTab = build_gamma_tab();

endpackage

>>> rtl/core/ntsc_cpc_req_if.sv
// ============================================================================
// Color index channel
// Valid/ready channel that carries one color index per item.
// ============================================================================
interface ntsc_cpc_req_if;
   logic       valid;
   logic       ready;
   logic [8:0] color_index;

   modport source (output valid, output color_index, input ready);
   modport sink   (input valid, input color_index, output ready);
endinterface

>>> rtl/core/ntsc_cpc_rsp_if.sv
// ============================================================================
// RGB result channel
// Valid/ready channel that carries one 16-bit RGB triple per item.
// ============================================================================
interface ntsc_cpc_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] red;
   logic [15:0] green;
   logic [15:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

>>> rtl/core/ntsc_cpc_gamma_rom.sv
// ============================================================================
// Gamma lookup ROM
// Registered read of the constant gamma table, held while not enabled.
// ============================================================================
module ntsc_cpc_gamma_rom (
   input  logic                                   clock,
   input  logic                                   enable,
   input  logic [ntsc_cpc_pkg::GammaTableBits-1:0] addr,
   output logic [15:0]                            data
);

   logic [15:0] data_ff;

   // Read the table on each enabled cycle.
   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= ntsc_cpc_pkg::GammaTab[addr];
      end
   end

   assign data = data_ff;

endmodule

>>> rtl/core/ntsc_composite_palette_color.sv
// ============================================================================
// Composite palette color converter
// Turns a 9-bit color index into a gamma-corrected 16-bit RGB triple.
// ============================================================================
//
//   Channel   Direction  Handshake       Payload
//   req_ch    in         valid/ready     color_index[8:0]
//   rsp_ch    out        valid/ready     red, green, blue [15:0]
//   csr_*     in         write enable    gamma mode bit
//
// Seven register stages; one item per cycle while the output does not stall.
// Stage 3 to 5 hold the Y, I/Q scaling and RGB matrix multipliers, which set
// the stage depth. Stage 7 is the gamma ROM read.
// Reset clears the valid bits and the gamma mode (linear).
// Each stage moves when it is empty or the next one moves, so bubbles close
// up and a stall at the output holds every item in place.
module ntsc_composite_palette_color (
   input  logic             clock,
   input  logic             reset,
   ntsc_cpc_req_if.sink     req_ch,
   ntsc_cpc_rsp_if.source   rsp_ch,
   input  logic             csr_wr_en,
   input  logic             csr_wr_data
);

   localparam int Ph = ntsc_cpc_pkg::Phases;
   localparam int Hp = ntsc_cpc_pkg::HalfPhases;
   localparam int Gb = ntsc_cpc_pkg::GammaTableBits;

   // Configuration register.
   logic mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (csr_wr_en) begin
         mode_ff <= csr_wr_data;
      end
   end

   // Stage valid bits and advance chain.
   logic [7:1] valid_ff;
   logic [8:1] adv;

   always_comb begin
      adv[8] = rsp_ch.ready;
      for (int k = 7; k >= 1; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[1]) begin
            valid_ff[1] <= req_ch.valid;
         end
         for (int k = 2; k <= 7; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   assign req_ch.ready = adv[1];

   // Stage 1: decode the index and form the twelve phase samples.
   logic [3:0]              hue;
   logic [1:0]              lum;
   logic [14:0]             low_lev;
   logic [14:0]             high_lev;
   logic [28:0]             low_att_full;
   logic [28:0]             high_att_full;
   logic [14:0]             spot;
   logic                    atten;
   logic signed [15:0]      d_in [Ph];
   logic signed [15:0]      d_ff [Ph];

   always_comb begin
      hue      = req_ch.color_index[3:0];
      lum      = (hue < 4'd14) ? req_ch.color_index[5:4] : 2'd1;
      low_lev  = ntsc_cpc_pkg::LevelTab[{hue == 4'd0, lum}];
      high_lev = ntsc_cpc_pkg::LevelTab[{hue < 4'd13, lum}];
      low_att_full  = 29'(low_lev) * 29'(ntsc_cpc_pkg::AttenQ14) + 29'd8192;
      high_att_full = 29'(high_lev) * 29'(ntsc_cpc_pkg::AttenQ14) + 29'd8192;
      for (int p = 0; p < Ph; p++) begin
         atten = (req_ch.color_index[6] && ntsc_cpc_pkg::in_wave(4'(p), 4'd12)) ||
                 (req_ch.color_index[7] && ntsc_cpc_pkg::in_wave(4'(p), 4'd4)) ||
                 (req_ch.color_index[8] && ntsc_cpc_pkg::in_wave(4'(p), 4'd8));
         if (ntsc_cpc_pkg::in_wave(4'(p), hue)) begin
            spot = atten ? high_att_full[28:14] : high_lev;
         end else begin
            spot = atten ? low_att_full[28:14] : low_lev;
         end
         d_in[p] = $signed({1'b0, spot}) - $signed({1'b0, ntsc_cpc_pkg::BlackQ14});
      end
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         d_ff <= d_in;
      end
   end

   // Stage 2: luma sum and half-period differences for the chroma sums.
   logic signed [19:0] ysum_in;
   logic signed [19:0] ysum_ff;
   logic signed [16:0] e_in [Hp];
   logic signed [16:0] e_ff [Hp];

   always_comb begin
      ysum_in = '0;
      for (int p = 0; p < Ph; p++) begin
         ysum_in = ysum_in + 20'(d_ff[p]);
      end
      for (int p = 0; p < Hp; p++) begin
         e_in[p] = 17'(d_ff[p]) - 17'(d_ff[p+Hp]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         ysum_ff <= ysum_in;
         e_ff    <= e_in;
      end
   end

   // Stage 3: chroma sums and scaled luma.
   logic signed [31:0] isum_in;
   logic signed [31:0] qsum_in;
   logic signed [31:0] isum_ff;
   logic signed [31:0] qsum_ff;
   logic signed [36:0] yprod;
   logic signed [36:0] yround;
   logic signed [17:0] y3_ff;

   always_comb begin
      isum_in = '0;
      qsum_in = '0;
      for (int p = 0; p < Hp; p++) begin
         isum_in = isum_in + 32'(e_ff[p]) * ntsc_cpc_pkg::CosTab[p];
         qsum_in = qsum_in + 32'(e_ff[p]) * ntsc_cpc_pkg::SinTab[p];
      end
      yprod  = 37'(ysum_ff) * ntsc_cpc_pkg::YScale;
      yround = (yprod + 37'sd524288) >>> 20;
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         isum_ff <= isum_in;
         qsum_ff <= qsum_in;
         y3_ff   <= yround[17:0];
      end
   end

   // Stage 4: scale I and Q.
   logic signed [50:0] iprod;
   logic signed [50:0] qprod;
   logic signed [50:0] iround;
   logic signed [50:0] qround;
   logic signed [17:0] i_ff;
   logic signed [17:0] q_ff;
   logic signed [17:0] y4_ff;

   always_comb begin
      iprod  = 51'(isum_ff) * ntsc_cpc_pkg::CScale;
      qprod  = 51'(qsum_ff) * ntsc_cpc_pkg::CScale;
      iround = (iprod + 51'sd8589934592) >>> 34;
      qround = (qprod + 51'sd8589934592) >>> 34;
   end

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         i_ff  <= iround[17:0];
         q_ff  <= qround[17:0];
         y4_ff <= y3_ff;
      end
   end

   // Stage 5: RGB matrix products.
   logic signed [35:0] acc_in [3];
   logic signed [35:0] acc_ff [3];
   logic signed [17:0] y5_ff;

   always_comb begin
      acc_in[0] = 36'(i_ff) * ntsc_cpc_pkg::CoefRI + 36'(q_ff) * ntsc_cpc_pkg::CoefRQ;
      acc_in[1] = 36'(i_ff) * ntsc_cpc_pkg::CoefGI + 36'(q_ff) * ntsc_cpc_pkg::CoefGQ;
      acc_in[2] = 36'(i_ff) * ntsc_cpc_pkg::CoefBI + 36'(q_ff) * ntsc_cpc_pkg::CoefBQ;
   end

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         acc_ff <= acc_in;
         y5_ff  <= y4_ff;
      end
   end

   // Stage 6: channel value, clamp flags, linear value and table address.
   logic signed [35:0] acc_round [3];
   logic signed [22:0] f_val [3];
   logic [30:0]        lin_full [3];
   logic [2:0]         zero_in;
   logic [2:0]         sat_in;
   logic [15:0]        lin_in [3];
   logic [Gb-1:0]      addr_in [3];
   logic [2:0]         zero6_ff;
   logic [2:0]         sat6_ff;
   logic [15:0]        lin6_ff [3];
   logic [Gb-1:0]      addr_ff [3];
   logic               mode6_ff;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         acc_round[c] = (acc_ff[c] + 36'sd8192) >>> 14;
         f_val[c]     = 23'(y5_ff) + acc_round[c][22:0];
         zero_in[c]   = (f_val[c] <= 23'sd0);
         sat_in[c]    = (f_val[c] >= $signed(23'(ntsc_cpc_pkg::FullQ14)));
         lin_full[c]  = 31'(f_val[c][13:0]) * 31'd65535;
         lin_in[c]    = lin_full[c][29:14];
         addr_in[c]   = f_val[c][13 -: Gb];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[6]) begin
         zero6_ff <= zero_in;
         sat6_ff  <= sat_in;
         lin6_ff  <= lin_in;
         addr_ff  <= addr_in;
         mode6_ff <= mode_ff;
      end
   end

   // Stage 7: gamma lookup, with the clamp and linear results carried alongside.
   logic [15:0] rom_data [3];
   logic [2:0]  zero7_ff;
   logic [2:0]  sat7_ff;
   logic [15:0] lin7_ff [3];
   logic        mode7_ff;
   logic [15:0] chan [3];

   for (genvar c = 0; c < 3; c++) begin : g_rom
      ntsc_cpc_gamma_rom u_rom (
         .clock  (clock),
         .enable (adv[7]),
         .addr   (addr_ff[c]),
         .data   (rom_data[c])
      );
   end

   always_ff @(posedge clock) begin
      if (adv[7]) begin
         zero7_ff <= zero6_ff;
         sat7_ff  <= sat6_ff;
         lin7_ff  <= lin6_ff;
         mode7_ff <= mode6_ff;
      end
   end

   // Output selection.
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         if (zero7_ff[c]) begin
            chan[c] = 16'd0;
         end else if (sat7_ff[c]) begin
            chan[c] = 16'hFFFF;
         end else if (mode7_ff) begin
            chan[c] = rom_data[c];
         end else begin
            chan[c] = lin7_ff[c];
         end
      end
   end

   assign rsp_ch.valid = valid_ff[7];
   assign rsp_ch.red   = chan[0];
   assign rsp_ch.green = chan[1];
   assign rsp_ch.blue  = chan[2];

endmodule

>>> rtl/core/ntsc_cpc_checker.sv
// ============================================================================
// Composite palette color checker
// Port-level checks on the converter, attached to it by a bind.
// ============================================================================
`include "ntsc_composite_palette_color_macros.svh"

module ntsc_cpc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_red,
   input logic [15:0] rsp_green,
   input logic [15:0] rsp_blue
);

   // The whole result payload, for the stability check.
   logic [47:0] rsp_data;

   assign rsp_data = {rsp_red, rsp_green, rsp_blue};

   // A stalled item stays offered.
   `CPC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "result item dropped")

   // A stalled item keeps its payload.
   `CPC_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_data), "result changed")

   // With the output draining, every stage moves, so the input is open.
   `CPC_ASSERT_SAME(a_ready_chain, rsp_ready, req_ready, "input blocked while output drains")

   // Nothing leaves the pipeline right after reset.
   `CPC_ASSERT_SAME(a_reset_empty, $fell(reset), !rsp_valid, "result item after reset")

endmodule

bind ntsc_composite_palette_color ntsc_cpc_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_red   (rsp_ch.red),
   .rsp_green (rsp_ch.green),
   .rsp_blue  (rsp_ch.blue)
);

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// Composite palette color testbench
// Drives color indexes through the converter under both gamma modes, with
// random gaps on the sender, random stalls on the receiver and one long
// output stall. Every RGB triple is checked against a local model of the
// composite wave decode.
// ============================================================================
module testbench;

   typedef struct packed {
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
   } rgb_type;

   localparam int CycleLimit = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic csr_wr_data = 1'b0;

   ntsc_cpc_req_if req_if ();
   ntsc_cpc_rsp_if rsp_if ();

   ntsc_composite_palette_color u_top (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_if),
      .rsp_ch      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Tables of the composite decode, Q14.
   int level_lut [8] = '{5734, 8487, 15761, 25395, 17924, 24674, 32145, 32145};
   int cos_lut [12] = '{16384, 14189, 8192, 0, -8192, -14189,
                        -16384, -14189, -8192, 0, 8192, 14189};
   int sin_lut [12] = '{0, 8192, 14189, 16384, 14189, 8192,
                        0, -8192, -14189, -16384, -14189, -8192};
   logic [15:0] curve_lut [1024];

   logic        gamma_sel = 1'b0;
   logic [8:0]  pending_idx [$];
   rgb_type     expected_rgb [$];
   bit          idle_on = 1'b0;
   bit          taken = 1'b0;
   int          send_gap = 0;
   int          recv_wait = 0;
   int          long_hold = 0;
   int          cycles = 0;
   int          errors = 0;
   int          checked = 0;
   int          gamma1_items = 0;

   always #5 clock = ~clock;

   // Q30 power, truncated after each multiply.
   function automatic longint unsigned q30_power(longint unsigned u, int n);
      longint unsigned p;
      p = u;
      for (int k = 1; k < n; k++) begin
         p = (p * u) >> 30;
      end
      return p;
   endfunction

   // Builds the 11/9 exponent curve by bisecting the ninth root.
   task automatic fill_curve();
      longint unsigned x, lo, hi, mid;
      for (int k = 0; k < 1024; k++) begin
         x  = longint'(k) << 20;
         lo = 0;
         hi = 64'd1 << 30;
         while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            if (q30_power(mid, 9) <= x) begin
               lo = mid;
            end else begin
               hi = mid - 1;
            end
         end
         curve_lut[k] = 16'((q30_power(lo, 11) * 65535) >> 30);
      end
   endtask

   function automatic bit high_phase(int p, int c);
      return ((c + p + 8) % 12) < 6;
   endfunction

   // Rounds half up, then floors; the shift is arithmetic.
   function automatic longint round_down(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic logic [15:0] channel_level(longint y, longint i, longint q,
                                                 longint ci, longint cq);
      longint f;
      f = y + round_down(ci * i + cq * q, 14);
      if (f <= 0) return 16'd0;
      if (f >= 16384) return 16'hFFFF;
      if (!gamma_sel) return 16'((f * 65535) >> 14);
      return curve_lut[f >> 4];
   endfunction

   // Decodes twelve phase samples of the wave into an RGB triple.
   function automatic rgb_type decode_color(logic [8:0] n);
      int hue, lum, lowlev, highlev, spot, d;
      longint ysum, isum, qsum, y, i, q;
      rgb_type r;
      hue = n[3:0];
      // Hues 14 and 15 are black and always use luma 1.
      lum = (hue < 14) ? int'(n[5:4]) : 1;
      lowlev  = level_lut[lum + ((hue == 0) ? 4 : 0)];
      highlev = level_lut[lum + ((hue < 13) ? 4 : 0)];
      ysum = 0; isum = 0; qsum = 0;
      for (int p = 0; p < 12; p++) begin
         spot = high_phase(p, hue) ? highlev : lowlev;
         if ((n[6] && high_phase(p, 12)) || (n[7] && high_phase(p, 4)) ||
             (n[8] && high_phase(p, 8))) begin
            spot = (spot * 12222 + 8192) >>> 14;
         end
         d = spot - 8487;
         ysum += d;
         isum += longint'(d) * cos_lut[p];
         qsum += longint'(d) * sin_lut[p];
      end
      y = round_down(ysum * 60514, 20);
      i = round_down(isum * 121027, 34);
      q = round_down(qsum * 121027, 34);
      r.red   = channel_level(y, i, q, 15514, 10216);
      r.green = channel_level(y, i, q, -4502, -10415);
      r.blue  = channel_level(y, i, q, -18162, 28000);
      return r;
   endfunction

   // Input acceptance and the prediction of its triple.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && req_if.valid && req_if.ready) begin
         expected_rgb.push_back(decode_color(req_if.color_index));
         if (gamma_sel) gamma1_items++;
         taken = 1'b1;
      end
      if (cycles > CycleLimit) begin
         $display("Timeout after %0d cycles.", cycles);
         $display("== FAIL ==");
         $finish;
      end
   end

   // Sender: presents the next pending item after a drawn gap.
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || taken) begin
         if (send_gap > 0) begin
            send_gap--;
            req_if.valid <= 1'b0;
         end else if (pending_idx.size() > 0) begin
            req_if.valid <= 1'b1;
            req_if.color_index <= pending_idx.pop_front();
            send_gap = idle_on ? $urandom_range(0, 13) : 0;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
      taken = 1'b0;
   end

   // Long output hold-off, counted down in cycles on its own.
   always @(posedge clock) begin
      if (long_hold > 0) long_hold--;
   end

   // Receiver: drawn stall per item, plus the long hold-off while it runs.
   always @(negedge clock) begin
      if (long_hold > 0) begin
         rsp_if.ready <= 1'b0;
      end else if (recv_wait > 0) begin
         recv_wait--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // Result check against the oldest prediction.
   always @(posedge clock) begin
      rgb_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         recv_wait = idle_on ? $urandom_range(0, 13) : 0;
         if (expected_rgb.size() == 0) begin
            errors++;
            if (errors <= 10) $display("Unexpected item: %h %h %h",
                                       rsp_if.red, rsp_if.green, rsp_if.blue);
         end else begin
            want = expected_rgb.pop_front();
            checked++;
            if (want.red !== rsp_if.red || want.green !== rsp_if.green ||
                want.blue !== rsp_if.blue) begin
               errors++;
               if (errors <= 10) begin
                  $display("Mismatch: expected %h %h %h, got %h %h %h",
                           want.red, want.green, want.blue,
                           rsp_if.red, rsp_if.green, rsp_if.blue);
               end
            end
         end
      end
   end

   // Waits for the pipeline to drain, then a few more cycles.
   task automatic drain();
      while (pending_idx.size() > 0 || req_if.valid || expected_rgb.size() > 0) begin
         @(posedge clock);
      end
      repeat (12) @(posedge clock);
   endtask

   task automatic set_gamma(logic mode);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_wr_data = mode;
      @(negedge clock);
      csr_wr_en = 1'b0;
      gamma_sel = mode;
   endtask

   task automatic queue_directed();
      logic [8:0] picks [20] = '{9'h000, 9'h1FF, 9'h00D, 9'h00E, 9'h00F, 9'h01E,
                                 9'h03F, 9'h030, 9'h020, 9'h010, 9'h001, 9'h00C,
                                 9'h040, 9'h080, 9'h100, 9'h1C0, 9'h1F0, 9'h03D,
                                 9'h126, 9'h0BA};
      foreach (picks[k]) pending_idx.push_back(picks[k]);
   endtask

   initial begin
      req_if.valid = 1'b0;
      req_if.color_index = '0;
      rsp_if.ready = 1'b0;
      fill_curve();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed corners in both gamma modes.
      queue_directed();
      drain();
      set_gamma(1'b1);
      queue_directed();
      drain();

      // Random phases; the second one starts with a long output stall.
      for (int ph = 0; ph < 6; ph++) begin
         set_gamma(ph[0]);
         idle_on = (ph % 3) != 2;
         if (ph == 1) long_hold = 300;
         for (int k = 0; k < 215; k++) pending_idx.push_back(9'($urandom));
         drain();
      end
      set_gamma(1'b0);

      $display("Checked %0d triples, %0d under the 11/9 curve, with random gaps",
               checked, gamma1_items);
      $display("and stalls on both channels and one long output stall.");
      if (errors == 0 && expected_rgb.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("Errors: %0d, left over: %0d", errors, expected_rgb.size());
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
